>>> design/vmpc_pkg.sv
`timescale 1ns / 1ps
package vmpc_pkg;
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_CLASSIFY = 2'd2;
  localparam logic [2:0] K_FORWARD = 3'd0;
  localparam logic [2:0] K_DROP = 3'd1;
  localparam logic [2:0] K_ADD_DONE = 3'd2;
  localparam logic [2:0] K_FULL = 3'd3;
  localparam logic [2:0] K_CLEAR = 3'd4;
  localparam logic [11:0] UNTAGGED_VID = 12'hfff;
  localparam logic [47:0] DUMMY_MAC = 48'h010000000000;
  localparam logic [15:0] VLAN_ETYPE = 16'h8100;
  localparam int VID_W = 12;
  localparam int VLAN_IDS = 4096;
  localparam int NUM_PORTS = 16;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] out_port;
    logic       is_copy;
    logic       last;
  } result_t;
endpackage

>>> design/vmpc_key_cmp.sv
`timescale 1ns / 1ps
module vmpc_key_cmp
  import vmpc_pkg::*;
(
  input  logic              valid_bit,
  input  logic [47:0]       entry_mac,
  input  logic [VID_W-1:0]  entry_vid,
  input  logic [47:0]       key_mac,
  input  logic [VID_W-1:0]  key_vid,
  output logic              hit
);
  assign hit = valid_bit && (entry_mac == key_mac) && (entry_vid == key_vid);
endmodule

>>> design/vlan_mac_port_classifier_core.sv
`timescale 1ns / 1ps
// Forwarding classifier by VLAN and destination MAC. Every item is a command
// (clear, add, classify); the block takes one item at a time and holds
// in_stall high while it works and while a result still sits in its one-entry
// output register. An add or a classify scans the exact-match table through
// one shared key comparator, one slot per cycle; a hit then reads the stored
// port before the result is formed. An add with a zero MAC and a classify on
// a VLAN with no member skip the scan, as does an add of the dummy MAC. A
// multicast miss then visits the ports in ascending order and emits a copy for
// each member port, waiting while the output is stalled, plus a copy to the
// untagged default when that is set and the VLAN is not the untagged one.
// After reset and after each clear the two per-VLAN memories are swept, one
// VLAN per cycle, with the input stalled. An opcode of three is taken and
// gives no result.
module vlan_mac_port_classifier_core
  import vmpc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [15:0] eth_type,
  input  logic [15:0] tag_control,
  input  logic [47:0] dest_mac,
  input  logic [11:0] entry_vid,
  input  logic [47:0] entry_mac,
  input  logic [3:0]  entry_port,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [3:0]  out_port,
  output logic        is_copy,
  output logic        last
);
  localparam int TW = $clog2(TABLE_ENTRIES);
  localparam int PW = $clog2(NUM_PORTS);
  localparam int MW = (NUM_PORTS < 16) ? NUM_PORTS : 16;

  localparam logic [3:0] S_SWEEP  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_RDW    = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_SCANW  = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_WRITE  = 4'd7;
  localparam logic [3:0] S_HITRD  = 4'd8;
  localparam logic [3:0] S_HITW   = 4'd9;
  localparam logic [3:0] S_MCAST  = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;
  localparam logic [3:0] S_GDEF   = 4'd12;
  localparam logic [3:0] S_RDV    = 4'd13;

  logic [3:0] state;

  logic [MW-1:0] member_mem [VLAN_IDS];
  logic [4:0]    def_mem    [VLAN_IDS];
  logic [47:0]   mac_mem    [TABLE_ENTRIES];
  logic [VID_W-1:0] vid_mem [TABLE_ENTRIES];
  logic [3:0]    port_mem   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] ent_valid;

  logic [VID_W:0]  sweep_cnt;
  logic [1:0]      cmd;
  logic [VID_W-1:0] vid;
  logic [47:0]     mac;
  logic [3:0]      port_in;
  logic [MW-1:0]   mem_rd;
  logic [4:0]      def_rd;
  logic [4:0]      gdef;
  logic [MW-1:0]   members;
  logic [4:0]      vdef;
  logic [TW:0]     scan;
  logic [TW-1:0]   scan_prev;
  logic [TW-1:0]   slot;
  logic            found;
  logic [TW-1:0]   free_slot;
  logic            free_found;
  logic [47:0]     rd_mac;
  logic [VID_W-1:0] rd_vid;
  logic [3:0]      rd_port;
  logic [PW:0]     pidx;
  logic            hit;
  logic [VID_W-1:0] rd_addr;
  logic            out_full;
  result_t         res;
  logic            ovfl_copy;

  vmpc_key_cmp u_cmp (
    .valid_bit (ent_valid[scan_prev]),
    .entry_mac (rd_mac),
    .entry_vid (rd_vid),
    .key_mac   (mac),
    .key_vid   (vid),
    .hit       (hit)
  );

  assign in_stall = (state != S_IDLE) || out_full;
  assign out_valid = out_full;
  assign kind = res.kind;
  assign out_port = res.out_port;
  assign is_copy = res.is_copy;
  assign last = res.last;

  // untagged default first, then the item's own vlan
  always_comb begin
    rd_addr = vid;
    if (state == S_RD) rd_addr = UNTAGGED_VID;
  end

  always_ff @(posedge clk) begin
    mem_rd <= member_mem[rd_addr];
    def_rd <= def_mem[rd_addr];
    rd_mac <= mac_mem[scan[TW-1:0]];
    rd_vid <= vid_mem[scan[TW-1:0]];
    rd_port <= port_mem[state == S_HITRD ? slot : scan[TW-1:0]];
    scan_prev <= scan[TW-1:0];
    if (state == S_SWEEP) begin
      member_mem[sweep_cnt[VID_W-1:0]] <= '0;
      def_mem[sweep_cnt[VID_W-1:0]] <= '0;
    end else if (state == S_WRITE) begin
      member_mem[vid] <= members | (MW'(1) << port_in[PW-1:0]);
      if (mac == DUMMY_MAC) def_mem[vid] <= {1'b1, port_in};
      else begin
        mac_mem[found ? slot : free_slot] <= mac;
        vid_mem[found ? slot : free_slot] <= vid;
        port_mem[found ? slot : free_slot] <= port_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      sweep_cnt <= '0;
      out_full <= 1'b0;
      ent_valid <= '0;
    end else begin
      if (out_full && !out_stall) out_full <= 1'b0;
      unique case (state)
        S_SWEEP: begin
          ent_valid <= '0;
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == (VID_W+1)'(VLAN_IDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !out_full) begin
            cmd <= op;
            port_in <= entry_port;
            if (op == OP_CLEAR) begin
              res <= '{K_CLEAR, 4'd0, 1'b0, 1'b1};
              out_full <= 1'b1;
              ent_valid <= '0;
              sweep_cnt <= '0;
              state <= S_SWEEP;
            end else if (op == OP_ADD) begin
              vid <= entry_vid;
              mac <= entry_mac;
              state <= S_RD;
            end else if (op == OP_CLASSIFY) begin
              vid <= (eth_type == VLAN_ETYPE) ? tag_control[11:0] : UNTAGGED_VID;
              mac <= dest_mac;
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          gdef <= def_rd;
          state <= S_RDV;
        end
        S_RDV: begin
          members <= mem_rd;
          vdef <= def_rd;
          scan <= '0;
          found <= 1'b0;
          free_found <= 1'b0;
          if (cmd == OP_ADD && (mac == '0 || 32'(port_in) >= NUM_PORTS)) begin
            state <= S_EMIT;
            res <= '{K_ADD_DONE, 4'd0, 1'b0, 1'b1};
          end else if (cmd == OP_ADD && mac == DUMMY_MAC) begin
            state <= S_WRITE;
          end else if (cmd == OP_CLASSIFY && mem_rd == '0) begin
            state <= S_EMIT;
            res <= gdef[4] ? '{K_FORWARD, gdef[3:0], 1'b0, 1'b1}
                           : '{K_DROP, 4'd0, 1'b0, 1'b1};
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan <= scan + 1'b1;
          state <= S_SCANW;
        end
        S_SCANW: begin
          if (hit && !found) begin
            found <= 1'b1;
            slot <= scan_prev;
          end
          if (!ent_valid[scan_prev] && !free_found) begin
            free_found <= 1'b1;
            free_slot <= scan_prev;
          end
          if (scan == (TW+1)'(TABLE_ENTRIES)) state <= S_DECIDE;
          else scan <= scan + 1'b1;
        end
        S_DECIDE: begin
          if (cmd == OP_ADD) begin
            if (found || free_found) state <= S_WRITE;
            else begin
              res <= '{K_FULL, 4'd0, 1'b0, 1'b1};
              state <= S_EMIT;
            end
          end else if (found) begin
            state <= S_HITRD;
          end else if (mac[40]) begin
            pidx <= '0;
            state <= S_MCAST;
          end else begin
            state <= S_EMIT;
            res <= vdef[4] ? '{K_FORWARD, vdef[3:0], 1'b0, 1'b1}
                 : gdef[4] ? '{K_FORWARD, gdef[3:0], 1'b0, 1'b1}
                 : '{K_DROP, 4'd0, 1'b0, 1'b1};
          end
        end
        S_WRITE: begin
          if (mac != DUMMY_MAC) ent_valid[found ? slot : free_slot] <= 1'b1;
          res <= '{K_ADD_DONE, 4'd0, 1'b0, 1'b1};
          state <= S_EMIT;
        end
        S_HITRD: state <= S_HITW;
        S_HITW: begin
          res <= '{K_FORWARD, rd_port, 1'b0, 1'b1};
          state <= S_EMIT;
        end
        S_MCAST: begin
          if (!(out_full && out_stall)) begin
            if (pidx == (PW+1)'(MW)) begin
              if (gdef[4] && vid != UNTAGGED_VID) state <= S_GDEF;
              else state <= S_IDLE;
            end else begin
              pidx <= pidx + 1'b1;
              if (members[pidx[PW-1:0]]) begin
                res <= '{K_FORWARD, 4'(pidx), 1'b1, ovfl_copy};
                out_full <= 1'b1;
              end
            end
          end
        end
        S_GDEF: begin
          if (!(out_full && out_stall)) begin
            res <= '{K_FORWARD, gdef[3:0], 1'b1, 1'b1};
            out_full <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!(out_full && out_stall)) begin
            out_full <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ovfl_copy = !(gdef[4] && vid != UNTAGGED_VID);
    for (int i = 0; i < MW; i++) begin
      if (i > 32'(pidx) && members[i]) ovfl_copy = 1'b0;
    end
  end
endmodule

>>> design/vmpc_checker.sv
`timescale 1ns / 1ps
module vmpc_checker
  import vmpc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] kind,
  input logic [3:0] out_port,
  input logic       is_copy,
  input logic       last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_port))
    else $error("output changed under stall");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= K_CLEAR)
    else $error("bad kind");
  a_port: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != K_FORWARD |-> out_port == 4'd0 && !is_copy && last)
    else $error("non forward result malformed");
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_FORWARD && !is_copy |-> last)
    else $error("single forward not marked last");
endmodule

bind vlan_mac_port_classifier_core vmpc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
  .out_port(out_port), .is_copy(is_copy), .last(last)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import vmpc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_CLEAR;
  logic [15:0] eth_type = '0;
  logic [15:0] tag_control = '0;
  logic [47:0] dest_mac = '0;
  logic [11:0] entry_vid = '0;
  logic [47:0] entry_mac = '0;
  logic [3:0]  entry_port = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [3:0]  out_port;
  logic        is_copy;
  logic        last;

  vlan_mac_port_classifier_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [1:0]  op;
    logic [15:0] etype;
    logic [15:0] tci;
    logic [47:0] dmac;
    logic [11:0] vid;
    logic [47:0] emac;
    logic [3:0]  port;
    bit          has_exp;
    logic [2:0]  exp_kind;
    logic [3:0]  exp_port;
  } cmd_t;

  localparam int SLOTS = 128;
  localparam int PORTS = 16;

  // forwarding state mirror
  bit          fdb_valid [SLOTS];
  logic [47:0] fdb_mac [SLOTS];
  logic [11:0] fdb_vid [SLOTS];
  logic [3:0]  fdb_port [SLOTS];
  logic [15:0] vlan_members [VLAN_IDS];
  bit          vlan_def_ok [VLAN_IDS];
  logic [3:0]  vlan_def [VLAN_IDS];

  result_t expected_results[$];
  int      errors = 0;
  bit      hold_long = 1'b0;
  bit      quiet_phase = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void wipe_tables();
    for (int i = 0; i < SLOTS; i++) fdb_valid[i] = 1'b0;
    for (int v = 0; v < VLAN_IDS; v++) begin
      vlan_members[v] = '0;
      vlan_def_ok[v] = 1'b0;
      vlan_def[v] = '0;
    end
  endfunction

  function automatic int fdb_find(logic [47:0] mac, logic [11:0] vid);
    for (int i = 0; i < SLOTS; i++)
      if (fdb_valid[i] && fdb_mac[i] == mac && fdb_vid[i] == vid) return i;
    return -1;
  endfunction

  function automatic void push_result(logic [2:0] k, logic [3:0] p, bit c);
    result_t r;
    r.kind = k;
    r.out_port = p;
    r.is_copy = c;
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic logic [2:0] learn_entry(logic [11:0] vid, logic [47:0] mac,
                                             logic [3:0] port);
    int slot;
    if (mac == '0 || port >= PORTS) return K_ADD_DONE;
    if (mac == DUMMY_MAC) begin
      vlan_members[vid][port] = 1'b1;
      vlan_def_ok[vid] = 1'b1;
      vlan_def[vid] = port;
      return K_ADD_DONE;
    end
    slot = fdb_find(mac, vid);
    if (slot < 0)
      for (int i = 0; i < SLOTS; i++)
        if (!fdb_valid[i]) begin
          slot = i;
          break;
        end
    if (slot < 0) return K_FULL;
    fdb_valid[slot] = 1'b1;
    fdb_mac[slot] = mac;
    fdb_vid[slot] = vid;
    fdb_port[slot] = port;
    vlan_members[vid][port] = 1'b1;
    return K_ADD_DONE;
  endfunction

  function automatic void classify_frame(cmd_t c);
    logic [11:0] vid;
    int slot;
    vid = (c.etype == VLAN_ETYPE) ? c.tci[11:0] : UNTAGGED_VID;
    if (vlan_members[vid] == '0) begin
      if (vlan_def_ok[UNTAGGED_VID]) push_result(K_FORWARD, vlan_def[UNTAGGED_VID], 1'b0);
      else push_result(K_DROP, '0, 1'b0);
      return;
    end
    slot = fdb_find(c.dmac, vid);
    if (slot >= 0) push_result(K_FORWARD, fdb_port[slot], 1'b0);
    else if (c.dmac[40]) begin
      for (int p = 0; p < PORTS; p++)
        if (vlan_members[vid][p]) push_result(K_FORWARD, p[3:0], 1'b1);
      if (vlan_def_ok[UNTAGGED_VID] && vid != UNTAGGED_VID)
        push_result(K_FORWARD, vlan_def[UNTAGGED_VID], 1'b1);
    end else if (vlan_def_ok[vid]) push_result(K_FORWARD, vlan_def[vid], 1'b0);
    else if (vlan_def_ok[UNTAGGED_VID]) push_result(K_FORWARD, vlan_def[UNTAGGED_VID], 1'b0);
    else push_result(K_DROP, '0, 1'b0);
  endfunction

  function automatic void predict_command(cmd_t c);
    int n;
    n = expected_results.size();
    case (c.op)
      OP_CLEAR: begin
        wipe_tables();
        push_result(K_CLEAR, '0, 1'b0);
      end
      OP_ADD: push_result(learn_entry(c.vid, c.emac, c.port), '0, 1'b0);
      OP_CLASSIFY: classify_frame(c);
      default: ;
    endcase
    if (expected_results.size() > n)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  task automatic send_command(cmd_t c);
    int n0;
    if (!quiet_phase && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= c.op;
    eth_type <= c.etype;
    tag_control <= c.tci;
    dest_mac <= c.dmac;
    entry_vid <= c.vid;
    entry_mac <= c.emac;
    entry_port <= c.port;
    do @(posedge clk); while (in_stall);
    n0 = expected_results.size();
    predict_command(c);
    if (c.has_exp && (expected_results.size() != n0 + 1 ||
        expected_results[n0].kind != c.exp_kind || expected_results[n0].out_port != c.exp_port))
      report($sformatf("table row op %0d disagrees with predictor", c.op));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst || hold_long) out_stall <= hold_long;
    else out_stall <= !quiet_phase && ($urandom_range(99) < 10);
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) report("result with nothing expected");
      else begin
        e = expected_results.pop_front();
        if (kind !== e.kind) report($sformatf("kind %0d want %0d", kind, e.kind));
        if (out_port !== e.out_port)
          report($sformatf("out_port %0d want %0d", out_port, e.out_port));
        if (is_copy !== e.is_copy) report($sformatf("is_copy %0b want %0b", is_copy, e.is_copy));
        if (last !== e.last) report($sformatf("last %0b want %0b", last, e.last));
      end
    end
  end

  function automatic cmd_t mk(logic [1:0] o, logic [15:0] et, logic [15:0] tc,
                              logic [47:0] dm, logic [11:0] v, logic [47:0] em,
                              logic [3:0] p, bit he = 0, logic [2:0] ek = 0,
                              logic [3:0] ep = 0);
    cmd_t c;
    c.op = o; c.etype = et; c.tci = tc; c.dmac = dm; c.vid = v; c.emac = em; c.port = p;
    c.has_exp = he; c.exp_kind = ek; c.exp_port = ep;
    return c;
  endfunction

  function automatic logic [47:0] rand_mac(bit pool);
    logic [47:0] m;
    m = 48'({$urandom, $urandom});
    if (pool) m = {8'h00, 8'h11, 24'h0, 4'h0, 4'($urandom_range(7))} |
                  (48'($urandom_range(1)) << 40);
    return m;
  endfunction

  function automatic logic [11:0] rand_vid();
    case ($urandom_range(3))
      0: return UNTAGGED_VID;
      1: return 12'd0;
      default: return 12'($urandom_range(3, 1));
    endcase
  endfunction

  function automatic cmd_t rand_command();
    cmd_t c;
    int r;
    logic [11:0] v;
    r = $urandom_range(99);
    v = rand_vid();
    c = mk(OP_CLASSIFY, 16'($urandom), 16'($urandom), rand_mac(1'($urandom_range(1))),
           rand_vid(), rand_mac(1'($urandom_range(1))), 4'($urandom));
    if (r < 2) c.op = OP_CLEAR;
    else if (r < 4) c.op = 2'd3;
    else if (r < 40) begin
      c.op = OP_ADD;
      if ($urandom_range(4) == 0) c.emac = DUMMY_MAC;
      else if ($urandom_range(9) == 0) c.emac = '0;
    end else begin
      if ($urandom_range(3) != 0) begin
        c.etype = (v == UNTAGGED_VID) ? 16'h0800 : VLAN_ETYPE;
        c.tci = {4'($urandom), v};
      end
    end
    return c;
  endfunction

  initial begin
    cmd_t dir[$];
    cmd_t c;
    int sent;
    wipe_tables();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    dir.push_back(mk(OP_CLASSIFY, VLAN_ETYPE, 16'hffff, 48'hffff_ffff_ffff, 0, 0, 0,
                     1, K_DROP, 0));
    dir.push_back(mk(OP_ADD, 0, 0, 0, 12'd5, 48'h0, 4'd3, 1, K_ADD_DONE, 0));
    dir.push_back(mk(OP_ADD, 0, 0, 0, 12'd5, 48'hffff_ffff_ffff, 4'd15, 1, K_ADD_DONE, 0));
    dir.push_back(mk(OP_ADD, 0, 0, 0, 12'd5, 48'h0000_0000_0001, 4'd0, 1, K_ADD_DONE, 0));
    dir.push_back(mk(OP_ADD, 0, 0, 0, 12'd5, DUMMY_MAC, 4'd7, 1, K_ADD_DONE, 0));
    dir.push_back(mk(OP_CLASSIFY, VLAN_ETYPE, 16'hf005, 48'hffff_ffff_ffff, 0, 0, 0,
                     1, K_FORWARD, 15));
    dir.push_back(mk(OP_CLASSIFY, VLAN_ETYPE, 16'h0005, 48'h0100_0000_0002, 0, 0, 0));
    dir.push_back(mk(OP_CLASSIFY, VLAN_ETYPE, 16'h0005, 48'h0000_0000_0002, 0, 0, 0,
                     1, K_FORWARD, 7));
    dir.push_back(mk(OP_CLASSIFY, 16'h0800, 0, 48'h0000_0000_0002, 0, 0, 0, 1, K_DROP, 0));
    dir.push_back(mk(OP_ADD, 0, 0, 0, UNTAGGED_VID, DUMMY_MAC, 4'd9, 1, K_ADD_DONE, 0));
    dir.push_back(mk(OP_CLASSIFY, VLAN_ETYPE, 16'h0123, 48'h0, 0, 0, 0, 1, K_FORWARD, 9));
    dir.push_back(mk(OP_CLASSIFY, VLAN_ETYPE, 16'h0005, 48'h0100_0000_0002, 0, 0, 0));
    dir.push_back(mk(OP_CLASSIFY, 16'h8101, 16'h0005, 48'h0000_0000_0002, 0, 0, 0,
                     1, K_FORWARD, 9));
    dir.push_back(mk(OP_CLASSIFY, 16'hffff, 0, 48'hffff_ffff_ffff, 0, 0, 0));
    dir.push_back(mk(2'd3, 16'hffff, 16'hffff, 48'hffff_ffff_ffff, 12'hfff,
                     48'hffff_ffff_ffff, 4'hf));
    for (int p = 0; p < PORTS; p++)
      dir.push_back(mk(OP_ADD, 0, 0, 0, 12'd0, DUMMY_MAC, 4'(p)));
    dir.push_back(mk(OP_CLASSIFY, VLAN_ETYPE, 16'h0000, 48'hff00_0000_0000, 0, 0, 0));
    dir.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1, K_CLEAR, 0));
    dir.push_back(mk(OP_CLASSIFY, 16'h0800, 0, 48'h0, 0, 0, 0, 1, K_DROP, 0));
    foreach (dir[i]) send_command(dir[i]);

    // fill the table to overflow
    for (int i = 0; i <= SLOTS; i++)
      send_command(mk(OP_ADD, 0, 0, 0, 12'd1, 48'h0000_0a00_0000 + 48'(i), 4'(i),
                      i == SLOTS, K_FULL, 0));
    send_command(mk(OP_ADD, 0, 0, 0, 12'd1, 48'h0000_0a00_0005, 4'd2, 1, K_ADD_DONE, 0));
    send_command(mk(OP_CLASSIFY, VLAN_ETYPE, 16'h0001, 48'h0000_0a00_0005, 0, 0, 0,
                    1, K_FORWARD, 2));
    send_command(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 1, K_CLEAR, 0));

    sent = 0;
    while (sent < 45) begin
      quiet_phase = (sent >= 10 && sent < 25);
      if (sent == 30) fork
        begin
          hold_long = 1'b1;
          repeat (3000) @(negedge clk);
          hold_long = 1'b0;
        end
      join_none
      c = rand_command();
      send_command(c);
      if (c.op != 2'd3) sent++;
    end
    in_valid <= 1'b0;
    quiet_phase = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

>>> vlan_mac_port_classifier_core.f
design/vmpc_pkg.sv
design/vmpc_key_cmp.sv
design/vlan_mac_port_classifier_core.sv
design/vmpc_checker.sv
tb/sv/tb_top.sv
